### hw/rtl/glm_pkg.sv
`default_nettype none

package glm_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int COUNT_W    = 18;
    localparam int NUM_COLS_W = 8;
    localparam int NUM_ROWS_W = 11;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 3;

    localparam int MAX_COLS_DEF = 128;
    localparam int MAX_ROWS_DEF = 1024;

    localparam logic [NUM_COLS_W-1:0] NUM_COLS_RST = 8'd128;
    localparam logic [NUM_ROWS_W-1:0] NUM_ROWS_RST = 11'd1024;

    // register index, taken from paddr[2]
    localparam logic REG_NUM_COLS = 1'b0;
    localparam logic REG_NUM_ROWS = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/grid_local_maxima_counter.sv
`default_nettype none

// After its last sample beat, a matrix's count passes the decision and result registers.
// Throughput: one sample per cycle; input stalls only while a finished count is not taken.
// Each element is decided by two delay chains, each as long as the clamped num_cols, holding the rows above.
// Reset (i_rst_n low, synchronous): position, counter and handshakes clear,
// num_cols returns to 128 and num_rows to 1024; delay cells keep their contents.
module grid_local_maxima_counter
    import glm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    parameter int MAX_ROWS = MAX_ROWS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_sample_valid,
    output logic                 o_sample_ready,
    input  logic signed [31:0]   i_sample,

    output logic                 o_count_valid,
    input  logic                 i_count_ready,
    output logic [COUNT_W-1:0]   o_maxima_count,

    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [DATA_W-1:0]    pwdata,
    output logic [DATA_W-1:0]    prdata,
    output logic                 pready
);

    localparam int LEN_W  = $clog2(MAX_COLS + 1);
    localparam int RLEN_W = $clog2(MAX_ROWS + 1);
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [NUM_COLS_W-1:0] r_num_cols;
    logic [NUM_ROWS_W-1:0] r_num_rows;
    logic [LEN_W-1:0]      eff_cols;
    logic [RLEN_W-1:0]     eff_rows;
    logic                  cfg_wr;

    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;
    logic                  in_acc;
    logic                  a_adv;
    logic                  slot_free;

    t_sample               age_n;
    t_sample               age_nm1;
    t_sample               age_2n;
    t_sample               r_age_n1;
    t_sample               r_prev1;
    t_sample               r_prev2;
    t_sample               x;

    logic                  c_ge1, c_ge2, r_ge1, r_ge2;
    logic                  has_right, col_last, last_row, emit;
    logic [2:0]            hits;

    logic                  r_a_valid;
    logic [2:0]            r_a_hits;
    logic                  r_a_last;
    logic [1:0]            inc;
    logic [COUNT_W-1:0]    sum;
    logic [COUNT_W-1:0]    r_count;
    logic                  r_out_valid;
    logic [COUNT_W-1:0]    r_out_count;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_cols <= NUM_COLS_RST;
            r_num_rows <= NUM_ROWS_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_NUM_COLS: r_num_cols <= pwdata[NUM_COLS_W-1:0];
                REG_NUM_ROWS: r_num_rows <= pwdata[NUM_ROWS_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_NUM_COLS: prdata = DATA_W'(r_num_cols);
            REG_NUM_ROWS: prdata = DATA_W'(r_num_rows);
        endcase
    end

    always_comb begin
        if (r_num_cols == '0) begin
            eff_cols = LEN_W'(1);
        end else if (32'(r_num_cols) > 32'(MAX_COLS)) begin
            eff_cols = LEN_W'(MAX_COLS);
        end else begin
            eff_cols = LEN_W'(r_num_cols);
        end
        if (r_num_rows == '0) begin
            eff_rows = RLEN_W'(1);
        end else if (32'(r_num_rows) > 32'(MAX_ROWS)) begin
            eff_rows = RLEN_W'(MAX_ROWS);
        end else begin
            eff_rows = RLEN_W'(r_num_rows);
        end
    end

    // handshake
    assign slot_free      = !r_out_valid || i_count_ready;
    assign a_adv          = !r_a_valid || !r_a_last || slot_free;
    assign o_sample_ready = a_adv;
    assign in_acc         = i_sample_valid && a_adv;
    assign x              = i_sample;

    // row delay chains: age n and n-1 from the first, age 2n from the second
    glm_line #(.MAX_COLS(MAX_COLS)) u_line_mid (
        .i_clk      (i_clk),
        .i_shift    (in_acc),
        .i_len      (eff_cols),
        .i_x        (x),
        .o_tail     (age_n),
        .o_pre_tail (age_nm1)
    );

    glm_line #(.MAX_COLS(MAX_COLS)) u_line_up (
        .i_clk      (i_clk),
        .i_shift    (in_acc),
        .i_len      (eff_cols),
        .i_x        (age_n),
        .o_tail     (age_2n),
        .o_pre_tail ()
    );

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_age_n1 <= age_n;
            r_prev1  <= x;
            r_prev2  <= r_prev1;
        end
    end

    // position
    assign c_ge1     = (r_col != '0);
    assign c_ge2     = (32'(r_col) >= 32'd2);
    assign r_ge1     = (r_row != '0);
    assign r_ge2     = (32'(r_row) >= 32'd2);
    assign has_right = (32'(r_col) + 32'd1 < 32'(eff_cols));
    assign col_last  = !has_right;
    assign last_row  = (32'(r_row) + 32'd1 >= 32'(eff_rows));
    assign emit      = last_row && col_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_acc) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= last_row ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // decisions: element above, left element in the last row, final element
    always_comb begin
        hits[0] = r_ge1 && (age_n > x)
                  && (!r_ge2 || age_n > age_2n)
                  && (!c_ge1 || age_n > r_age_n1)
                  && (!has_right || age_n > age_nm1);
        hits[1] = last_row && c_ge1 && (r_prev1 > x)
                  && (!r_ge1 || r_prev1 > r_age_n1)
                  && (!c_ge2 || r_prev1 > r_prev2);
        hits[2] = emit
                  && (!r_ge1 || x > age_n)
                  && (!c_ge1 || x > r_prev1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_adv) begin
            r_a_valid <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_hits <= hits;
            r_a_last <= emit;
        end
    end

    // counting and result register
    assign inc = {1'b0, r_a_hits[0]} + {1'b0, r_a_hits[1]} + {1'b0, r_a_hits[2]};
    assign sum = r_count + COUNT_W'(inc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_count <= '0;
        end else if (r_a_valid && a_adv) begin
            r_count <= r_a_last ? '0 : sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_a_valid && r_a_last && a_adv) begin
            r_out_valid <= 1'b1;
        end else if (i_count_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && r_a_last && a_adv) begin
            r_out_count <= sum;
        end
    end

    assign o_count_valid  = r_out_valid;
    assign o_maxima_count = r_out_count;

`ifndef SYNTHESIS
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) < 32'(eff_cols))
        else $error("column index out of range");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < 32'(eff_rows))
        else $error("row index out of range");

    a_emit_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_a_valid && r_a_last))
        else $error("count beat without a final element");

    a_last_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_last && !slot_free) |=> (r_a_valid && r_a_last))
        else $error("final element lost while result stalled");
`endif

endmodule

`default_nettype wire

### hw/rtl/glm_cell.sv
`default_nettype none

module glm_cell
    import glm_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_sample   i_x,
    input  t_sample   i_prev,
    output t_sample   o_data
);

    t_sample r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_data <= i_ctl.load ? i_x : i_prev;
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

### hw/rtl/glm_line.sv
`default_nettype none

module glm_line
    import glm_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int LEN_W = $clog2(MAX_COLS + 1),
    localparam int POS_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic [LEN_W-1:0] i_len,
    input  t_sample          i_x,
    output t_sample          o_tail,
    output t_sample          o_pre_tail
);

    // delay of i_len beats: new data enters at cell MAX_COLS - i_len
    logic [POS_W-1:0] ins_pos;
    t_sample          chain [MAX_COLS];

    assign ins_pos = POS_W'(MAX_COLS - int'(i_len));

    for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
        t_cell_ctl ctl;
        t_sample   prev;

        assign ctl.shift = i_shift;
        assign ctl.load  = (ins_pos == POS_W'(i));

        if (i == 0) begin : g_head
            assign prev = i_x;
        end else begin : g_body
            assign prev = chain[i-1];
        end

        glm_cell u_cell (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_x    (i_x),
            .i_prev (prev),
            .o_data (chain[i])
        );
    end

    assign o_tail = chain[MAX_COLS-1];

    if (MAX_COLS > 1) begin : g_pre
        assign o_pre_tail = chain[MAX_COLS-2];
    end else begin : g_pre_one
        assign o_pre_tail = chain[0];
    end

endmodule

`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import glm_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS   = 1900;
    localparam t_sample SMIN = 32'sh8000_0000;
    localparam t_sample SMAX = 32'sh7FFF_FFFF;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_sample_valid = 1'b0;
    logic                o_sample_ready;
    t_sample             i_sample       = '0;
    logic                o_count_valid;
    logic                i_count_ready  = 1'b0;
    logic [COUNT_W-1:0]  o_maxima_count;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    grid_local_maxima_counter dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sample_valid (i_sample_valid),
        .o_sample_ready (o_sample_ready),
        .i_sample       (i_sample),
        .o_count_valid  (o_count_valid),
        .i_count_ready  (i_count_ready),
        .o_maxima_count (o_maxima_count),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #2 i_clk = ~i_clk;

    // shadow registers and the matrix collected so far
    logic [NUM_COLS_W-1:0] cols_reg = NUM_COLS_RST;
    logic [NUM_ROWS_W-1:0] rows_reg = NUM_ROWS_RST;
    t_sample               frame[$];
    t_sample               sample_q[$];
    logic [COUNT_W-1:0]    count_q[$];
    logic [COUNT_W-1:0]    want_count;
    int                    mismatches  = 0;
    int                    idle_cycles = 0;

    function automatic int active_cols();
        if (cols_reg == 0) return 1;
        return (cols_reg > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_reg);
    endfunction

    function automatic int active_rows();
        if (rows_reg == 0) return 1;
        return (rows_reg > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_reg);
    endfunction

    // strict peaks against every neighbour that exists
    function automatic logic [COUNT_W-1:0] count_peaks(input int cols, input int rows);
        logic [COUNT_W-1:0] total;
        t_sample            v;
        bit                 peak;
        total = '0;
        for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
                v    = frame[r*cols + c];
                peak = 1'b1;
                if (r > 0 && v <= frame[(r-1)*cols + c]) peak = 1'b0;
                if (r < rows-1 && v <= frame[(r+1)*cols + c]) peak = 1'b0;
                if (c > 0 && v <= frame[r*cols + c-1]) peak = 1'b0;
                if (c < cols-1 && v <= frame[r*cols + c+1]) peak = 1'b0;
                if (peak) total = total + 1'b1;
            end
        end
        return total;
    endfunction

    function automatic void take_sample(input t_sample x);
        int cols;
        int rows;
        cols = active_cols();
        rows = active_rows();
        frame.push_back(x);
        if (frame.size() == cols*rows) begin
            count_q.push_back(count_peaks(cols, rows));
            frame.delete();
        end
    endfunction

    function automatic t_sample pick_sample(input int flavor);
        case (flavor)
            0: return t_sample'($urandom());
            1: return t_sample'($urandom_range(0, 6)) - 3;
            default: begin
                case ($urandom_range(0, 4))
                    0: return SMIN;
                    1: return SMAX;
                    2: return 0;
                    3: return -1;
                    default: return 1;
                endcase
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        $display("count beat error: %s", msg);
        mismatches++;
    endtask

    // sample driver: bursts and gaps, occasional drain of pending counts
    int burst_left = 0;
    int gap_left   = 0;
    int bursts     = 0;
    bit drain_hold = 1'b0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_sample_valid <= 1'b0;
        end else begin
            if (i_sample_valid && o_sample_ready) begin
                take_sample(i_sample);
            end
            if (!i_sample_valid || o_sample_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_sample_valid <= 1'b0;
                end else if (drain_hold) begin
                    if (count_q.size() == 0) drain_hold = 1'b0;
                    i_sample_valid <= 1'b0;
                end else if (sample_q.size() > 0) begin
                    i_sample       <= sample_q.pop_front();
                    i_sample_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                                                  : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        bursts++;
                        drain_hold = (bursts % 12 == 0);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_sample_valid <= 1'b0;
                end
            end
        end
    end

    // count receiver: stall pattern switches between modes
    int stall_mode = 0;
    int stall_left = 0;

    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(8, 64);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: i_count_ready <= 1'b1;
            1: i_count_ready <= 1'($urandom_range(0, 1));
            2: i_count_ready <= ($urandom_range(0, 7) == 0);
            default: i_count_ready <= 1'b0;
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_count_valid && i_count_ready) begin
            if (count_q.size() == 0) begin
                report_mismatch($sformatf("unexpected count %0d", o_maxima_count));
            end else begin
                want_count = count_q.pop_front();
                if (o_maxima_count !== want_count) begin
                    report_mismatch($sformatf("maxima_count %0d, want %0d",
                                              o_maxima_count, want_count));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_sample_valid && o_sample_ready) || (o_count_valid && i_count_ready) ||
            (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_NUM_COLS) cols_reg = data[NUM_COLS_W-1:0];
        else rows_reg = data[NUM_ROWS_W-1:0];
        frame.delete();
    endtask

    task automatic set_size(input int cols_val, input int rows_val);
        apb_write({REG_NUM_COLS, 2'b00}, cols_val);
        apb_write({REG_NUM_ROWS, 2'b00}, rows_val);
    endtask

    task automatic wait_idle();
        while (sample_q.size() > 0 || i_sample_valid || count_q.size() > 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic queue_samples(input int count, input int flavor, inout int queued);
        repeat (count) sample_q.push_back(pick_sample(flavor));
        queued += count;
    endtask

    initial begin
        int queued;
        int cols_val;
        int rows_val;
        int beats;
        int flavor;
        int mode;
        int frames;

        queued = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // partial matrix at the reset size, abandoned by the next write
        queue_samples(5, 0, queued);
        wait_idle();

        set_size(1, 1);
        sample_q.push_back(SMAX);
        sample_q.push_back(SMIN);
        sample_q.push_back(0);
        wait_idle();

        set_size(0, 0);
        sample_q.push_back(-5);
        wait_idle();

        set_size(3, 3);
        for (int k = 0; k < 9; k++) sample_q.push_back((k % 2 == 0) ? SMAX : SMIN);
        wait_idle();

        // plateau: no strict peak
        set_size(2, 2);
        repeat (4) sample_q.push_back(-1);
        wait_idle();

        // size extremes, clamped and exact
        queued = 0;
        set_size(255, 1);
        queue_samples(MAX_COLS_DEF, 0, queued);
        wait_idle();
        set_size(128, 2);
        queue_samples(2*MAX_COLS_DEF, 1, queued);
        wait_idle();
        set_size(0, 2047);
        queue_samples(MAX_ROWS_DEF, 2, queued);
        wait_idle();

        while (queued < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: cols_val = $urandom_range(1, 6);
                6, 7: cols_val = $urandom_range(7, 20);
                8: cols_val = 0;
                default: cols_val = $urandom_range(121, 255);
            endcase
            if (cols_val > 20) rows_val = $urandom_range(0, 2);
            else if ($urandom_range(0, 9) == 0) rows_val = 0;
            else if ($urandom_range(0, 8) == 0) rows_val = $urandom_range(7, 12);
            else rows_val = $urandom_range(1, 6);

            // a single-register write only where the matrix stays small
            mode = $urandom_range(0, 2);
            if (cols_val > 20 || active_cols() > 20 || active_rows() > 12) mode = 2;

            case (mode)
                0: apb_write({REG_NUM_COLS, 2'b00}, cols_val);
                1: apb_write({REG_NUM_ROWS, 2'b00}, rows_val);
                default: set_size(cols_val, rows_val);
            endcase

            beats  = active_cols() * active_rows();
            frames = (beats > 64) ? 1 : $urandom_range(1, 4);
            repeat (frames) begin
                flavor = $urandom_range(0, 2);
                queue_samples(beats, flavor, queued);
            end
            if (beats > 1 && $urandom_range(0, 4) == 0) begin
                queue_samples($urandom_range(1, beats - 1), $urandom_range(0, 2), queued);
            end
            wait_idle();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
